@@ src/breakpoint_table_macros.svh @@
// assertion macros used by the breakpoint table controller
`ifndef BREAKPOINT_TABLE_MACROS_SVH
`define BREAKPOINT_TABLE_MACROS_SVH

// same-cycle implication on clock, quiet during reset
`define BT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication on clock, quiet during reset
`define BT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/bt_pkg.sv @@
// shared constants, codes and control types of the breakpoint table
package bt_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam logic [2:0] OP_TOGGLE_EXEC = 3'd0;
   localparam logic [2:0] OP_QUERY_EXEC  = 3'd1;
   localparam logic [2:0] OP_QUERY_COND  = 3'd2;
   localparam logic [2:0] OP_ADD_MEMORY  = 3'd3;
   localparam logic [2:0] OP_SET_ENABLE  = 3'd4;
   localparam logic [2:0] OP_SET_COND    = 3'd5;
   localparam logic [2:0] OP_REMOVE      = 3'd6;
   localparam logic [2:0] OP_CLEAR       = 3'd7;

   localparam logic [1:0] TYPE_EXEC  = 2'd0;
   localparam logic [1:0] TYPE_READ  = 2'd1;
   localparam logic [1:0] TYPE_WRITE = 2'd2;

   localparam logic [15:0] EXEC_SIZE = 16'd2;

   typedef struct packed {
      logic             load;
      logic             scan_start;
      logic             scan_step;
      logic [IDX_W-1:0] scan_idx;
      logic             commit;
   } bt_cmd_type;

endpackage

@@ src/bt_ctrl.sv @@
// controller state machine of the breakpoint table
`include "breakpoint_table_macros.svh"

module bt_ctrl import bt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output bt_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;
   localparam logic [1:0] ST_OUT    = 2'd3;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             req_take;
   logic             scan_last;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign req_take  = req_valid && !req_stall;
   assign scan_last = (scan_ff == LAST_IDX);

   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      unique case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            if (req_take) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_COMMIT;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_COMMIT: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
   end

   assign cmd.load       = req_take;
   assign cmd.scan_start = req_take;
   assign cmd.scan_step  = (state_ff == ST_SCAN);
   assign cmd.scan_idx   = scan_ff;
   assign cmd.commit     = (state_ff == ST_COMMIT);

   `BT_ASSERT_NEXT(a_take_scan, req_take, (state_ff == ST_SCAN) && (scan_ff == '0), "scan did not start")
   `BT_ASSERT_NEXT(a_scan_end, (state_ff == ST_SCAN) && scan_last, state_ff == ST_COMMIT, "scan overran")
   `BT_ASSERT_NEXT(a_commit_out, state_ff == ST_COMMIT, rsp_valid, "no response after commit")
   `BT_ASSERT_NOW(a_one_item, rsp_valid, req_stall, "request taken while response pending")

endmodule

@@ src/bt_datapath.sv @@
// table storage, scan trackers, counters and response registers
module bt_datapath import bt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  bt_cmd_type  cmd,
   input  logic [2:0]  req_kind,
   input  logic [1:0]  req_cpu_index,
   input  logic [31:0] req_address,
   input  logic [15:0] req_watch_size,
   input  logic        req_access_type,
   input  logic [31:0] req_target_id,
   input  logic        req_flag_value,
   output logic        rsp_found,
   output logic        rsp_added,
   output logic [31:0] rsp_entry_id,
   output logic [1:0]  rsp_entry_cpu,
   output logic        rsp_entry_enabled,
   output logic        rsp_entry_has_condition,
   output logic        rsp_table_full,
   output logic [31:0] rsp_generation
);

   // table
   logic [ENTRIES-1:0] valid_ff;
   logic [31:0]        id_ff   [ENTRIES];
   logic [1:0]         type_ff [ENTRIES];
   logic [1:0]         cpu_ff  [ENTRIES];
   logic [31:0]        addr_ff [ENTRIES];
   logic [15:0]        size_ff [ENTRIES];
   logic [ENTRIES-1:0] en_ff;
   logic [ENTRIES-1:0] cond_ff;

   // captured transaction
   logic [2:0]  op_ff;
   logic [1:0]  cap_cpu_ff;
   logic [31:0] cap_addr_ff;
   logic [15:0] cap_size_ff;
   logic [1:0]  cap_mtype_ff;
   logic [31:0] cap_tid_ff;
   logic        cap_flag_ff;

   // scan trackers
   logic             a_hit_ff, b_hit_ff, free_hit_ff;
   logic [IDX_W-1:0] a_idx_ff, b_idx_ff, free_idx_ff;
   logic [31:0]      a_id_ff, b_id_ff;
   logic [1:0]       a_cpu_ff, b_cpu_ff;
   logic             a_en_ff, b_en_ff, a_cond_ff, b_cond_ff;

   logic [31:0] next_id_ff, gen_ff, gen_in;

   logic [IDX_W-1:0] i;
   logic             v, m_exec, m_cond, m_mem, m_id, m_pri;

   assign i      = cmd.scan_idx;
   assign v      = valid_ff[i];
   assign m_exec = v && type_ff[i] == TYPE_EXEC && cpu_ff[i] == cap_cpu_ff
                   && addr_ff[i] == cap_addr_ff;
   assign m_cond = v && en_ff[i] && type_ff[i] == TYPE_EXEC && addr_ff[i] == cap_addr_ff
                   && cond_ff[i];
   assign m_mem  = v && type_ff[i] == cap_mtype_ff && addr_ff[i] == cap_addr_ff
                   && size_ff[i] == cap_size_ff;
   assign m_id   = v && id_ff[i] == cap_tid_ff;

   always_comb begin
      unique case (op_ff)
         OP_TOGGLE_EXEC, OP_QUERY_EXEC: m_pri = m_exec;
         OP_QUERY_COND:                 m_pri = m_cond;
         OP_ADD_MEMORY:                 m_pri = m_mem;
         OP_SET_ENABLE:                 m_pri = m_id && (en_ff[i] != cap_flag_ff);
         default:                       m_pri = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= req_kind;
         cap_cpu_ff   <= req_cpu_index;
         cap_addr_ff  <= req_address;
         cap_size_ff  <= req_watch_size;
         cap_mtype_ff <= req_access_type ? TYPE_WRITE : TYPE_READ;
         cap_tid_ff   <= req_target_id;
         cap_flag_ff  <= req_flag_value;
      end
   end

   // lowest id wins, ties to lowest slot since the scan ascends
   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         a_hit_ff    <= 1'b0;
         b_hit_ff    <= 1'b0;
         free_hit_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         if (m_pri && (!a_hit_ff || id_ff[i] < a_id_ff)) begin
            a_hit_ff  <= 1'b1;
            a_idx_ff  <= i;
            a_id_ff   <= id_ff[i];
            a_cpu_ff  <= cpu_ff[i];
            a_en_ff   <= en_ff[i];
            a_cond_ff <= cond_ff[i];
         end
         if (m_id && (!b_hit_ff || id_ff[i] < b_id_ff)) begin
            b_hit_ff  <= 1'b1;
            b_idx_ff  <= i;
            b_id_ff   <= id_ff[i];
            b_cpu_ff  <= cpu_ff[i];
            b_en_ff   <= en_ff[i];
            b_cond_ff <= cond_ff[i];
         end
         if (!v && !free_hit_ff) begin
            free_hit_ff <= 1'b1;
            free_idx_ff <= i;
         end
      end
   end

   // commit decode
   logic             ins_en, del_en, en_set, cond_set, clr_all;
   logic [IDX_W-1:0] tgt_idx;
   logic [1:0]       ins_type, ins_cpu;
   logic [15:0]      ins_size;
   logic             found_in, added_in, full_in;
   logic [31:0]      eid_in;
   logic [1:0]       ecpu_in;
   logic             een_in, econd_in;

   always_comb begin
      ins_en   = 1'b0;
      del_en   = 1'b0;
      en_set   = 1'b0;
      cond_set = 1'b0;
      clr_all  = 1'b0;
      tgt_idx  = a_idx_ff;
      ins_type = TYPE_EXEC;
      ins_cpu  = cap_cpu_ff;
      ins_size = EXEC_SIZE;
      found_in = 1'b0;
      added_in = 1'b0;
      full_in  = 1'b0;
      eid_in   = '0;
      ecpu_in  = '0;
      een_in   = 1'b0;
      econd_in = 1'b0;
      gen_in   = gen_ff;
      unique case (op_ff)
         OP_TOGGLE_EXEC, OP_ADD_MEMORY: begin
            if (op_ff == OP_ADD_MEMORY) begin
               ins_type = cap_mtype_ff;
               ins_cpu  = 2'd0;
               ins_size = cap_size_ff;
            end
            if (a_hit_ff) begin
               found_in = 1'b1;
               eid_in   = a_id_ff;
               ecpu_in  = a_cpu_ff;
               een_in   = a_en_ff;
               econd_in = a_cond_ff;
               if (op_ff == OP_TOGGLE_EXEC) begin
                  del_en = 1'b1;
                  gen_in = gen_ff + 32'd1;
               end
            end else if (free_hit_ff) begin
               ins_en   = 1'b1;
               tgt_idx  = free_idx_ff;
               added_in = 1'b1;
               eid_in   = next_id_ff;
               ecpu_in  = ins_cpu;
               een_in   = 1'b1;
               gen_in   = gen_ff + 32'd1;
            end else begin
               full_in = 1'b1;
            end
         end
         OP_QUERY_EXEC, OP_QUERY_COND: begin
            if (a_hit_ff) begin
               found_in = 1'b1;
               eid_in   = a_id_ff;
               ecpu_in  = a_cpu_ff;
               een_in   = a_en_ff;
               econd_in = a_cond_ff;
            end
         end
         OP_SET_ENABLE: begin
            if (a_hit_ff) begin
               en_set   = 1'b1;
               found_in = 1'b1;
               eid_in   = a_id_ff;
               ecpu_in  = a_cpu_ff;
               een_in   = cap_flag_ff;
               econd_in = a_cond_ff;
               gen_in   = gen_ff + 32'd1;
            end else if (b_hit_ff) begin
               found_in = 1'b1;
               eid_in   = b_id_ff;
               ecpu_in  = b_cpu_ff;
               een_in   = b_en_ff;
               econd_in = b_cond_ff;
            end
         end
         OP_SET_COND, OP_REMOVE: begin
            tgt_idx = b_idx_ff;
            if (b_hit_ff) begin
               found_in = 1'b1;
               eid_in   = b_id_ff;
               ecpu_in  = b_cpu_ff;
               een_in   = b_en_ff;
               econd_in = b_cond_ff;
               if (op_ff == OP_SET_COND) begin
                  cond_set = 1'b1;
                  econd_in = cap_flag_ff;
               end else begin
                  del_en = 1'b1;
                  gen_in = gen_ff + 32'd1;
               end
            end
         end
         default: begin
            clr_all = 1'b1;
            if (|valid_ff) begin
               gen_in = gen_ff + 32'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         next_id_ff <= 32'd1;
         gen_ff     <= '0;
      end else if (cmd.commit) begin
         gen_ff <= gen_in;
         if (clr_all) begin
            valid_ff <= '0;
         end else if (del_en) begin
            valid_ff[tgt_idx] <= 1'b0;
         end else if (ins_en) begin
            valid_ff[tgt_idx] <= 1'b1;
            next_id_ff        <= next_id_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (ins_en) begin
            id_ff[tgt_idx]   <= next_id_ff;
            type_ff[tgt_idx] <= ins_type;
            cpu_ff[tgt_idx]  <= ins_cpu;
            addr_ff[tgt_idx] <= cap_addr_ff;
            size_ff[tgt_idx] <= ins_size;
            en_ff[tgt_idx]   <= 1'b1;
            cond_ff[tgt_idx] <= 1'b0;
         end
         if (en_set) begin
            en_ff[tgt_idx] <= cap_flag_ff;
         end
         if (cond_set) begin
            cond_ff[tgt_idx] <= cap_flag_ff;
         end
         rsp_found               <= found_in;
         rsp_added               <= added_in;
         rsp_table_full          <= full_in;
         rsp_entry_id            <= eid_in;
         rsp_entry_cpu           <= ecpu_in;
         rsp_entry_enabled       <= een_in;
         rsp_entry_has_condition <= econd_in;
      end
   end

   assign rsp_generation = gen_ff;

endmodule

@@ src/breakpoint_table.sv @@
// breakpoint table top level: controller plus datapath
//
// usage
//  - req_* carries one command transaction (kind selects toggle, query,
//    conditional query, add watch, set enable, set condition, remove, clear)
//  - rsp_* returns exactly one result transaction per command
//  - a transaction moves on a rising edge with valid high and stall low
// timing
//  - one command at a time: after acceptance the table is scanned one slot
//    per cycle, then the commit state writes back
//  - rsp_valid rises after the scan and the commit state, so the slot scan
//    sets the wait from acceptance to the result
//  - a new command is accepted the cycle after the result is taken
// reset
//  - synchronous, active high: all slots invalid, next id 1, generation 0
// stalls
//  - while rsp_stall is high the result holds and req_stall stays high
module breakpoint_table import bt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [1:0]  req_cpu_index,
   input  logic [31:0] req_address,
   input  logic [15:0] req_watch_size,
   input  logic        req_access_type,
   input  logic [31:0] req_target_id,
   input  logic        req_flag_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_found,
   output logic        rsp_added,
   output logic [31:0] rsp_entry_id,
   output logic [1:0]  rsp_entry_cpu,
   output logic        rsp_entry_enabled,
   output logic        rsp_entry_has_condition,
   output logic        rsp_table_full,
   output logic [31:0] rsp_generation
);

   // command bundle from sequencer to table
   bt_cmd_type cmd;

   bt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // table, lowest-id match trackers and result registers
   bt_datapath u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .req_kind                (req_kind),
      .req_cpu_index           (req_cpu_index),
      .req_address             (req_address),
      .req_watch_size          (req_watch_size),
      .req_access_type         (req_access_type),
      .req_target_id           (req_target_id),
      .req_flag_value          (req_flag_value),
      .rsp_found               (rsp_found),
      .rsp_added               (rsp_added),
      .rsp_entry_id            (rsp_entry_id),
      .rsp_entry_cpu           (rsp_entry_cpu),
      .rsp_entry_enabled       (rsp_entry_enabled),
      .rsp_entry_has_condition (rsp_entry_has_condition),
      .rsp_table_full          (rsp_table_full),
      .rsp_generation          (rsp_generation)
   );

endmodule

@@ tb/sv/tb.sv @@
// testbench for the breakpoint table: directed and random commands against a local predictor
module tb;
   import bt_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind = OP_CLEAR;
   logic [1:0]  req_cpu_index = '0;
   logic [31:0] req_address = '0;
   logic [15:0] req_watch_size = '0;
   logic        req_access_type = 1'b0;
   logic [31:0] req_target_id = '0;
   logic        req_flag_value = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_found, rsp_added;
   logic [31:0] rsp_entry_id;
   logic [1:0]  rsp_entry_cpu;
   logic        rsp_entry_enabled, rsp_entry_has_condition, rsp_table_full;
   logic [31:0] rsp_generation;

   typedef struct packed {
      logic        found;
      logic        added;
      logic [31:0] id;
      logic [1:0]  cpu;
      logic        enabled;
      logic        cond;
      logic        full;
      logic [31:0] generation;
   } outcome_type;

   breakpoint_table dut (.*);

   always #10 clock = ~clock;

   // predictor copy of the table
   logic        bp_live [ENTRIES];
   logic [31:0] bp_id [ENTRIES];
   logic [1:0]  bp_type [ENTRIES];
   logic [1:0]  bp_cpu [ENTRIES];
   logic [31:0] bp_addr [ENTRIES];
   logic [15:0] bp_size [ENTRIES];
   logic        bp_en [ENTRIES];
   logic        bp_cond [ENTRIES];
   logic [31:0] id_next;
   logic [31:0] gen_count;

   outcome_type pending_outcomes [$];
   int          mismatches = 0;
   int          outcomes_seen = 0;
   int          cycle_count = 0;
   bit          quiet_phase = 1'b0;
   bit          hold_off = 1'b0;
   int          hold_cycles = 0;

   // lowest id wins, lowest slot on a tie
   function automatic int best_match(int mode, logic [1:0] cpu, logic [31:0] addr,
                                     logic [1:0] typ, logic [15:0] size,
                                     logic [31:0] id, logic flag);
      int best;
      bit m;
      best = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!bp_live[i]) continue;
         case (mode)
            0: m = bp_type[i] == TYPE_EXEC && bp_cpu[i] == cpu && bp_addr[i] == addr;
            1: m = bp_en[i] && bp_type[i] == TYPE_EXEC && bp_addr[i] == addr && bp_cond[i];
            2: m = bp_type[i] == typ && bp_addr[i] == addr && bp_size[i] == size;
            3: m = bp_id[i] == id;
            default: m = bp_id[i] == id && bp_en[i] != flag;
         endcase
         if (m && (best < 0 || bp_id[i] < bp_id[best])) best = i;
      end
      return best;
   endfunction

   function automatic int place_entry(logic [1:0] typ, logic [1:0] cpu, logic [31:0] addr,
                                      logic [15:0] size);
      for (int i = 0; i < ENTRIES; i++) begin
         if (!bp_live[i]) begin
            bp_live[i] = 1'b1;
            bp_id[i]   = id_next;
            id_next    = id_next + 1;
            bp_type[i] = typ;
            bp_cpu[i]  = cpu;
            bp_addr[i] = addr;
            bp_size[i] = size;
            bp_en[i]   = 1'b1;
            bp_cond[i] = 1'b0;
            gen_count  = gen_count + 1;
            return i;
         end
      end
      return -1;
   endfunction

   function automatic void fill_entry(ref outcome_type o, input int s);
      o.id = bp_id[s];
      o.cpu = bp_cpu[s];
      o.enabled = bp_en[s];
      o.cond = bp_cond[s];
   endfunction

   function automatic outcome_type apply_command(logic [2:0] op, logic [1:0] cpu,
                                                 logic [31:0] addr, logic [15:0] size,
                                                 logic rw, logic [31:0] id, logic flag);
      outcome_type o;
      int s;
      bit any;
      logic [1:0] typ;
      o = '0;
      case (op)
         OP_TOGGLE_EXEC: begin
            s = best_match(0, cpu, addr, 0, 0, 0, 0);
            if (s >= 0) begin
               o.found = 1; fill_entry(o, s);
               bp_live[s] = 0; gen_count = gen_count + 1;
            end else begin
               s = place_entry(TYPE_EXEC, cpu, addr, EXEC_SIZE);
               if (s >= 0) begin o.added = 1; fill_entry(o, s); end
               else o.full = 1;
            end
         end
         OP_QUERY_EXEC, OP_QUERY_COND: begin
            s = best_match(op == OP_QUERY_EXEC ? 0 : 1, cpu, addr, 0, 0, 0, 0);
            if (s >= 0) begin o.found = 1; fill_entry(o, s); end
         end
         OP_ADD_MEMORY: begin
            typ = rw ? TYPE_WRITE : TYPE_READ;
            s = best_match(2, 0, addr, typ, size, 0, 0);
            if (s >= 0) begin o.found = 1; fill_entry(o, s); end
            else begin
               s = place_entry(typ, 0, addr, size);
               if (s >= 0) begin o.added = 1; fill_entry(o, s); end
               else o.full = 1;
            end
         end
         OP_SET_ENABLE: begin
            s = best_match(4, 0, 0, 0, 0, id, flag);
            if (s >= 0) begin bp_en[s] = flag; gen_count = gen_count + 1; end
            else s = best_match(3, 0, 0, 0, 0, id, 0);
            if (s >= 0) begin o.found = 1; fill_entry(o, s); end
         end
         OP_SET_COND: begin
            s = best_match(3, 0, 0, 0, 0, id, 0);
            if (s >= 0) begin bp_cond[s] = flag; o.found = 1; fill_entry(o, s); end
         end
         OP_REMOVE: begin
            s = best_match(3, 0, 0, 0, 0, id, 0);
            if (s >= 0) begin
               o.found = 1; fill_entry(o, s);
               bp_live[s] = 0; gen_count = gen_count + 1;
            end
         end
         default: begin
            any = 0;
            for (int i = 0; i < ENTRIES; i++) begin
               if (bp_live[i]) any = 1;
               bp_live[i] = 0;
            end
            if (any) gen_count = gen_count + 1;
         end
      endcase
      o.generation = gen_count;
      return o;
   endfunction

   // an id that is currently installed, or a stray one
   function automatic logic [31:0] pick_id();
      int s;
      if ($urandom_range(0, 4) == 0) return $urandom();
      s = $urandom_range(0, ENTRIES - 1);
      if (bp_live[s]) return bp_id[s];
      return id_next - $urandom_range(1, 3);
   endfunction

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("timeout at %0t", $time);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: random stall bursts, or a long hold-off when asked
   initial begin
      int burst;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            hold_cycles = 0;
            while (hold_off) begin
               @(posedge clock);
               hold_cycles++;
               if (hold_cycles >= 120) hold_off = 1'b0;
            end
            rsp_stall <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 10);
            rsp_stall <= 1'b1;
            repeat (burst - 1) @(posedge clock);
            @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // result checker: compares each accepted result transaction with the oldest expectation
   always @(posedge clock) begin
      outcome_type want, got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_found, rsp_added, rsp_entry_id, rsp_entry_cpu, rsp_entry_enabled,
                rsp_entry_has_condition, rsp_table_full, rsp_generation};
         outcomes_seen++;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            mismatches++;
         end else begin
            want = pending_outcomes.pop_front();
            if (got !== want) begin
               mismatches++;
               $display("%0t: expected found=%b added=%b id=%h cpu=%0d en=%b cond=%b full=%b gen=%h",
                        $time, want.found, want.added, want.id, want.cpu, want.enabled,
                        want.cond, want.full, want.generation);
               $display("%0t: actual   found=%b added=%b id=%h cpu=%0d en=%b cond=%b full=%b gen=%h",
                        $time, got.found, got.added, got.id, got.cpu, got.enabled,
                        got.cond, got.full, got.generation);
            end
         end
      end
   end

   // offers one command transaction, with an optional idle burst first
   task automatic send_command(logic [2:0] op, logic [1:0] cpu, logic [31:0] addr,
                               logic [15:0] size, logic rw, logic [31:0] id, logic flag);
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= op;
      req_cpu_index   <= cpu;
      req_address     <= addr;
      req_watch_size  <= size;
      req_access_type <= rw;
      req_target_id   <= id;
      req_flag_value  <= flag;
      do @(posedge clock); while (req_stall);
      pending_outcomes.insert(pending_outcomes.size(),
                              apply_command(op, cpu, addr, size, rw, id, flag));
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      drop_valid();
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic random_command();
      logic [31:0] addr;
      addr = ($urandom_range(0, 3) == 0) ? $urandom() : 32'h100 + 2 * $urandom_range(0, 7);
      send_command($urandom_range(0, 7) == 7 && $urandom_range(0, 3) == 0 ? OP_CLEAR
                      : 3'($urandom_range(0, 6)),
                   2'($urandom_range(0, 3)), addr,
                   $urandom_range(0, 1) ? 16'($urandom_range(1, 4)) : 16'($urandom()),
                   1'($urandom_range(0, 1)), pick_id(), 1'($urandom_range(0, 1)));
   endtask

   // extremes of every field, every operation and the special cases
   task automatic test_directed();
      send_command(OP_QUERY_EXEC, 0, 0, 0, 0, 0, 0);
      send_command(OP_CLEAR, 3, '1, '1, 1, '1, 1);          // clear of empty table
      send_command(OP_TOGGLE_EXEC, 3, '1, '1, 1, '1, 1);    // insert exec
      send_command(OP_TOGGLE_EXEC, 0, '1, 0, 0, 0, 0);      // same address other cpu
      send_command(OP_QUERY_EXEC, 3, '1, 0, 0, 0, 0);
      send_command(OP_SET_COND, 0, 0, 0, 0, 1, 1);
      send_command(OP_QUERY_COND, 2, '1, 0, 0, 0, 0);       // any cpu matches
      send_command(OP_SET_ENABLE, 0, 0, 0, 0, 1, 0);
      send_command(OP_SET_ENABLE, 0, 0, 0, 0, 1, 0);        // no change
      send_command(OP_QUERY_COND, 0, '1, 0, 0, 0, 0);       // disabled: no match
      send_command(OP_ADD_MEMORY, 0, 0, '1, 1, 0, 0);
      send_command(OP_ADD_MEMORY, 0, 0, '1, 1, 0, 0);       // deduplicated
      send_command(OP_ADD_MEMORY, 0, 0, '1, 0, 0, 0);       // read kind differs
      send_command(OP_REMOVE, 0, 0, 0, 0, 2, 0);
      send_command(OP_REMOVE, 0, 0, 0, 0, '1, 0);           // unknown id
      send_command(OP_TOGGLE_EXEC, 3, '1, 0, 0, 0, 0);      // toggle removes
      send_command(OP_SET_COND, 0, 0, 0, 0, 99, 1);
      for (int i = 0; i < ENTRIES + 1; i++)                // fill until refused
         send_command(i[0] ? OP_ADD_MEMORY : OP_TOGGLE_EXEC, 1, 32'h2000 + i, 4, 0, 0, 0);
      send_command(OP_CLEAR, 0, 0, 0, 0, 0, 0);
      wait_drained();
   endtask

   // receiver holds off while commands keep coming
   task automatic test_backpressure();
      hold_off = 1'b1;
      repeat (6) random_command();
      wait_drained();
   endtask

   // sender pauses until everything has come back between bursts
   task automatic test_random();
      for (int n = 0; n < 380; n++) begin
         random_command();
         if (n % 50 == 49) wait_drained();
         if (n == 330) quiet_phase = 1'b1;
      end
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < ENTRIES; i++) bp_live[i] = 1'b0;
      id_next = 1;
      gen_count = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random();
      repeat (40) @(posedge clock);
      $display("covered %0d results: all eight operations, full table, dedup, id lookups",
               outcomes_seen);
      $display("with random stalls, a long receiver hold-off and drained pauses");
      if (mismatches == 0 && pending_outcomes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
